// ===== hw/rtl/pfgc_pkg.sv =====
// Shared constants, codes and controller/datapath types for the gather crossbar.
`timescale 1ns / 1ps
package pfgc_pkg;

    localparam int CHANNELS      = 4;
    localparam int CH_W          = 2;
    localparam int LINE_ELEMENTS = 4;
    localparam int ELEMENT_WIDTH = 16;
    localparam int LINE_WIDTH    = LINE_ELEMENTS * ELEMENT_WIDTH;
    localparam int OUT_ELEMENTS  = 16;
    localparam int PROGRAM_DEPTH = 64;
    localparam int SLOT_W        = 6;
    localparam int STEPS_MAX     = 8;
    localparam int STEP_W        = 3;
    localparam int NSTEP_W       = 4;
    localparam int PROG_ADDR_W   = SLOT_W + STEP_W;
    localparam int GCNT_W        = 6;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_PROG  = 2'd1,
        CMD_ISSUE = 2'd2,
        CMD_NONE  = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        KIND_PUSH_ACK = 2'd0,
        KIND_PROG_ACK = 2'd1,
        KIND_ELEMENT  = 2'd2,
        KIND_STALL    = 2'd3
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CHANNELS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_RESP    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_PROG,
        ST_SCAN_RD,
        ST_SCAN_USE,
        ST_CHECK,
        ST_STALL,
        ST_G_RD,
        ST_G_LOAD,
        ST_G_EMIT,
        ST_PAD
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_PUSH,
        OP_PROG,
        OP_SCAN,
        OP_GSTART,
        OP_GLOAD,
        OP_ELEM,
        OP_SKIP,
        OP_PAD,
        OP_STALL,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        logic   in_ready;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic     in_valid;
        command_t in_command;
        logic     out_free;
        logic     issue_ready;
        logic     steps_done;
        logic     range_empty;
        logic     elem_at_last;
        logic     vec_full;
    } dp_stat_t;

endpackage

// ===== hw/rtl/pfgc_ifs.sv =====
// Request, result and configuration channel interfaces of the gather crossbar.
`timescale 1ns / 1ps
interface pfgc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [1:0]  channel;
    logic [63:0] line_data;
    logic [5:0]  program_index;
    logic [2:0]  step_index;
    logic [2:0]  step_source;
    logic [1:0]  start_element;
    logic [1:0]  end_element;
    logic        pop_after;
    logic        final_step;
    logic        dest_ready;

    modport source (
        output valid, command, channel, line_data, program_index, step_index,
               step_source, start_element, end_element, pop_after, final_step,
               dest_ready,
        input  ready
    );
    modport sink (
        input  valid, command, channel, line_data, program_index, step_index,
               step_source, start_element, end_element, pop_after, final_step,
               dest_ready,
        output ready
    );
endinterface

interface pfgc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic               accepted;
    logic signed [15:0] element_value;
    logic [3:0]         element_index;
    logic [2:0]         dest_channel;
    logic               last;
    logic               fifo_almost_full;
    logic               all_received;
    logic               overflow;

    modport source (
        output valid, kind, accepted, element_value, element_index, dest_channel,
               last, fifo_almost_full, all_received, overflow,
        input  ready
    );
    modport sink (
        input  valid, kind, accepted, element_value, element_index, dest_channel,
               last, fifo_almost_full, all_received, overflow,
        output ready
    );
endinterface

interface pfgc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pfgc_ctrl.sv =====
// Sequencing state machine of the gather crossbar.
`timescale 1ns / 1ps
module pfgc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  pfgc_pkg::dp_stat_t stat,
    output pfgc_pkg::dp_cmd_t  cmd
);

    pfgc_pkg::state_t state_reg;
    pfgc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfgc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.in_ready = 1'b0;
        cmd.op       = pfgc_pkg::OP_NONE;
        case (state_reg)
            pfgc_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.op = pfgc_pkg::OP_LATCH;
                    case (stat.in_command)
                        pfgc_pkg::CMD_PUSH:  state_next = pfgc_pkg::ST_PUSH;
                        pfgc_pkg::CMD_PROG:  state_next = pfgc_pkg::ST_PROG;
                        pfgc_pkg::CMD_ISSUE: state_next = pfgc_pkg::ST_SCAN_RD;
                        default:             state_next = pfgc_pkg::ST_IDLE;
                    endcase
                end
            end
            pfgc_pkg::ST_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = pfgc_pkg::OP_PUSH;
                    state_next = pfgc_pkg::ST_IDLE;
                end
            end
            pfgc_pkg::ST_PROG:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = pfgc_pkg::OP_PROG;
                    state_next = pfgc_pkg::ST_IDLE;
                end
            end
            pfgc_pkg::ST_SCAN_RD:
            begin
                state_next = stat.steps_done ? pfgc_pkg::ST_CHECK : pfgc_pkg::ST_SCAN_USE;
            end
            pfgc_pkg::ST_SCAN_USE:
            begin
                cmd.op     = pfgc_pkg::OP_SCAN;
                state_next = pfgc_pkg::ST_SCAN_RD;
            end
            pfgc_pkg::ST_CHECK:
            begin
                if (stat.issue_ready)
                begin
                    cmd.op     = pfgc_pkg::OP_GSTART;
                    state_next = pfgc_pkg::ST_G_RD;
                end
                else
                begin
                    state_next = pfgc_pkg::ST_STALL;
                end
            end
            pfgc_pkg::ST_STALL:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = pfgc_pkg::OP_STALL;
                    state_next = pfgc_pkg::ST_IDLE;
                end
            end
            pfgc_pkg::ST_G_RD:
            begin
                state_next = stat.steps_done ? pfgc_pkg::ST_PAD : pfgc_pkg::ST_G_LOAD;
            end
            pfgc_pkg::ST_G_LOAD:
            begin
                cmd.op     = pfgc_pkg::OP_GLOAD;
                state_next = pfgc_pkg::ST_G_EMIT;
            end
            pfgc_pkg::ST_G_EMIT:
            begin
                if (stat.range_empty)
                begin
                    cmd.op     = pfgc_pkg::OP_SKIP;
                    state_next = pfgc_pkg::ST_G_RD;
                end
                else if (stat.vec_full || stat.out_free)
                begin
                    cmd.op = pfgc_pkg::OP_ELEM;
                    if (stat.elem_at_last)
                    begin
                        state_next = pfgc_pkg::ST_G_RD;
                    end
                end
            end
            pfgc_pkg::ST_PAD:
            begin
                if (stat.vec_full)
                begin
                    cmd.op     = pfgc_pkg::OP_FINISH;
                    state_next = pfgc_pkg::ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.op = pfgc_pkg::OP_PAD;
                end
            end
            default:
            begin
                state_next = pfgc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pfgc_dp.sv =====
// Datapath of the gather crossbar: line FIFOs, program store, counters, result register.
`timescale 1ns / 1ps
module pfgc_dp #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    pfgc_in_if.sink            in_ch,
    pfgc_out_if.source         out_ch,
    pfgc_cfg_if.sink           cfg,
    input  pfgc_pkg::dp_cmd_t  cmd,
    output pfgc_pkg::dp_stat_t stat
);

    localparam int HW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = $clog2(2 * FIFO_DEPTH);
    localparam int LD = pfgc_pkg::CHANNELS * FIFO_DEPTH;
    localparam int LA = $clog2(LD);
    localparam int NW = pfgc_pkg::NSTEP_W;
    localparam int GW = pfgc_pkg::GCNT_W;

    // configuration
    logic [6:0]  plen_reg;
    logic [3:0]  occ_reg;
    logic [31:0] exp_reg;

    // latched request
    logic [1:0]                    item_channel_reg;
    logic [63:0]                   item_line_reg;
    logic [pfgc_pkg::SLOT_W-1:0]   item_slot_reg;
    logic [pfgc_pkg::STEP_W-1:0]   item_step_reg;
    logic [2:0]                    item_src_reg;
    logic [1:0]                    item_first_reg;
    logic [1:0]                    item_last_reg;
    logic                          item_pop_reg;
    logic                          item_final_reg;
    logic                          item_dready_reg;

    // architectural state
    logic [CW-1:0]               fifo_count_reg [pfgc_pkg::CHANNELS];
    logic [HW-1:0]               fifo_head_reg  [pfgc_pkg::CHANNELS];
    logic [pfgc_pkg::SLOT_W-1:0] pc_reg;
    logic [2:0]                  dest_reg;
    logic [31:0]                 rc_reg;

    // memories
    logic [NW-1:0]                 spi_mem [pfgc_pkg::PROGRAM_DEPTH];
    logic [pfgc_pkg::PROGRAM_DEPTH-1:0] spi_valid_reg;
    logic [NW-1:0]                 n_q;
    logic                          n_valid_q;
    logic [7:0]                    prog_mem [pfgc_pkg::PROGRAM_DEPTH * pfgc_pkg::STEPS_MAX];
    logic [7:0]                    prog_q;
    logic [63:0]                   line_mem [LD];
    logic [63:0]                   line_q;

    // issue working registers
    logic [NW-1:0] need_reg [pfgc_pkg::CHANNELS];
    logic [NW-1:0] pops_reg [pfgc_pkg::CHANNELS];
    logic [GW-1:0] total_reg;
    logic [NW-1:0] step_reg;
    logic [1:0]    elem_reg;
    logic [1:0]    cur_last_reg;
    logic          cur_empty_reg;
    logic          line_zero_reg;
    logic [GW-1:0] cnt_reg;

    // result register
    logic                 out_valid_reg;
    pfgc_pkg::kind_t      out_kind_reg;
    logic                 out_acc_reg;
    logic signed [15:0]   out_val_reg;
    logic [3:0]           out_idx_reg;
    logic [2:0]           out_dest_reg;
    logic                 out_last_reg;
    logic                 out_af_reg;
    logic                 out_ar_reg;
    logic                 out_ov_reg;

    logic                       out_free;
    logic                       emit;
    logic [NW-1:0]              n_eff;
    logic [2:0]                 p_src;
    logic [1:0]                 p_first;
    logic [1:0]                 p_last;
    logic                       p_pop;
    logic                       src_ok;
    logic [pfgc_pkg::CH_W-1:0]  src_c;
    logic [pfgc_pkg::CH_W-1:0]  sel_c;
    logic [CW-1:0]              sel_count;
    logic [HW-1:0]              sel_head;
    logic [SW-1:0]              tail_sum;
    logic [HW-1:0]              tail;
    logic [HW-1:0]              head_inc;
    logic                       push_ok;
    logic [CW-1:0]              count_after;
    logic [31:0]                rc_after;
    logic [LA-1:0]              line_waddr;
    logic [LA-1:0]              line_raddr;
    logic [2:0]                 range_len;
    logic                       ready_all;
    logic [15:0]                elem_val;
    logic [3:0]                 dest_inc;
    logic [6:0]                 pc_inc;
    logic                       vec_full;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = cmd.in_ready;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign n_eff    = n_valid_q ? n_q : '0;
    assign p_src    = prog_q[2:0];
    assign p_first  = prog_q[4:3];
    assign p_last   = prog_q[6:5];
    assign p_pop    = prog_q[7];
    assign src_ok   = (p_src != 3'd0) && (p_src <= 3'(pfgc_pkg::CHANNELS));
    assign src_c    = pfgc_pkg::CH_W'(p_src - 3'd1);
    assign sel_c    = (cmd.op == pfgc_pkg::OP_PUSH) ? item_channel_reg : src_c;
    assign sel_count = fifo_count_reg[sel_c];
    assign sel_head  = fifo_head_reg[sel_c];

    assign tail_sum = SW'(sel_head) + SW'(sel_count);
    assign tail     = (tail_sum >= SW'(FIFO_DEPTH)) ? HW'(tail_sum - SW'(FIFO_DEPTH))
                                                    : HW'(tail_sum);
    assign head_inc = (sel_head == HW'(FIFO_DEPTH - 1)) ? '0 : sel_head + 1'b1;
    assign push_ok  = sel_count < CW'(FIFO_DEPTH);
    assign count_after = push_ok ? sel_count + 1'b1 : sel_count;
    assign rc_after    = push_ok ? rc_reg + 32'd1 : rc_reg;

    assign line_waddr = LA'(sel_c) * LA'(FIFO_DEPTH) + LA'(tail);
    assign line_raddr = LA'(sel_c) * LA'(FIFO_DEPTH) + LA'(sel_head);

    assign range_len = (p_last >= p_first) ? 3'(p_last - p_first) + 3'd1 : 3'd0;
    assign vec_full  = cnt_reg >= GW'(pfgc_pkg::OUT_ELEMENTS);
    assign elem_val  = line_zero_reg ? 16'd0
                     : line_q[elem_reg * pfgc_pkg::ELEMENT_WIDTH +: pfgc_pkg::ELEMENT_WIDTH];
    assign dest_inc  = 4'(dest_reg) + 4'd1;
    assign pc_inc    = 7'(pc_reg) + 7'd1;

    always_comb
    begin
        ready_all = item_dready_reg;
        for (int c = 0; c < pfgc_pkg::CHANNELS; c++)
        begin
            if (fifo_count_reg[c] < CW'(need_reg[c]))
            begin
                ready_all = 1'b0;
            end
        end
    end

    assign emit = (cmd.op == pfgc_pkg::OP_PUSH) || (cmd.op == pfgc_pkg::OP_PROG)
               || (cmd.op == pfgc_pkg::OP_STALL) || (cmd.op == pfgc_pkg::OP_PAD)
               || ((cmd.op == pfgc_pkg::OP_ELEM) && !vec_full);

    assign stat.in_valid     = in_ch.valid;
    assign stat.in_command   = pfgc_pkg::command_t'(in_ch.command);
    assign stat.out_free     = out_free;
    assign stat.issue_ready  = ready_all;
    assign stat.steps_done   = step_reg >= n_eff;
    assign stat.range_empty  = cur_empty_reg;
    assign stat.elem_at_last = elem_reg == cur_last_reg;
    assign stat.vec_full     = vec_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= 7'd1;
            occ_reg  <= 4'd1;
            exp_reg  <= 32'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pfgc_pkg::CFG_PROGRAM_LENGTH:  plen_reg <= cfg.data[6:0];
                pfgc_pkg::CFG_OUTPUT_CHANNELS: occ_reg  <= cfg.data[3:0];
                pfgc_pkg::CFG_EXPECTED_RESP:   exp_reg  <= cfg.data;
                default:                       plen_reg <= plen_reg;
            endcase
        end
    end

    // latch the request
    always_ff @(posedge clk)
    begin
        if (cmd.op == pfgc_pkg::OP_LATCH)
        begin
            item_channel_reg <= in_ch.channel;
            item_line_reg    <= in_ch.line_data;
            item_slot_reg    <= in_ch.program_index;
            item_step_reg    <= in_ch.step_index;
            item_src_reg     <= in_ch.step_source;
            item_first_reg   <= in_ch.start_element;
            item_last_reg    <= in_ch.end_element;
            item_pop_reg     <= in_ch.pop_after;
            item_final_reg   <= in_ch.final_step;
            item_dready_reg  <= in_ch.dest_ready;
        end
    end

    // FIFO occupancy, pointers, counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < pfgc_pkg::CHANNELS; c++)
            begin
                fifo_count_reg[c] <= '0;
                fifo_head_reg[c]  <= '0;
            end
            pc_reg   <= '0;
            dest_reg <= '0;
            rc_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                pfgc_pkg::OP_PUSH:
                begin
                    if (push_ok)
                    begin
                        fifo_count_reg[sel_c] <= count_after;
                        rc_reg                <= rc_after;
                    end
                end
                pfgc_pkg::OP_GLOAD:
                begin
                    if (src_ok && p_pop && (sel_count != '0))
                    begin
                        fifo_head_reg[sel_c]  <= head_inc;
                        fifo_count_reg[sel_c] <= sel_count - 1'b1;
                    end
                end
                pfgc_pkg::OP_FINISH:
                begin
                    dest_reg <= (dest_inc >= occ_reg) ? 3'd0 : dest_inc[2:0];
                    pc_reg   <= (pc_inc >= plen_reg || pc_inc >= 7'(pfgc_pkg::PROGRAM_DEPTH))
                              ? '0 : pc_inc[pfgc_pkg::SLOT_W-1:0];
                end
                default:
                begin
                    rc_reg <= rc_reg;
                end
            endcase
        end
    end

    // step count store with valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spi_valid_reg <= '0;
            n_valid_q     <= 1'b0;
        end
        else
        begin
            n_valid_q <= spi_valid_reg[pc_reg];
            if ((cmd.op == pfgc_pkg::OP_PROG) && (item_src_reg <= 3'(pfgc_pkg::CHANNELS))
                && item_final_reg)
            begin
                spi_valid_reg[item_slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_q <= spi_mem[pc_reg];
        if ((cmd.op == pfgc_pkg::OP_PROG) && (item_src_reg <= 3'(pfgc_pkg::CHANNELS))
            && item_final_reg)
        begin
            spi_mem[item_slot_reg] <= NW'(item_step_reg) + 1'b1;
        end
    end

    // program step store
    always_ff @(posedge clk)
    begin
        prog_q <= prog_mem[{pc_reg, step_reg[pfgc_pkg::STEP_W-1:0]}];
        if ((cmd.op == pfgc_pkg::OP_PROG) && (item_src_reg <= 3'(pfgc_pkg::CHANNELS)))
        begin
            prog_mem[{item_slot_reg, item_step_reg}] <=
                {item_pop_reg, item_last_reg, item_first_reg, item_src_reg};
        end
    end

    // line store
    always_ff @(posedge clk)
    begin
        if (cmd.op == pfgc_pkg::OP_GLOAD)
        begin
            line_q <= line_mem[line_raddr];
        end
        if ((cmd.op == pfgc_pkg::OP_PUSH) && push_ok)
        begin
            line_mem[line_waddr] <= item_line_reg;
        end
    end

    // scan and gather working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pfgc_pkg::OP_LATCH:
            begin
                for (int c = 0; c < pfgc_pkg::CHANNELS; c++)
                begin
                    need_reg[c] <= '0;
                    pops_reg[c] <= '0;
                end
                total_reg <= '0;
                step_reg  <= '0;
            end
            pfgc_pkg::OP_SCAN:
            begin
                if (src_ok)
                begin
                    if (pops_reg[src_c] + 1'b1 > need_reg[src_c])
                    begin
                        need_reg[src_c] <= pops_reg[src_c] + 1'b1;
                    end
                    if (p_pop)
                    begin
                        pops_reg[src_c] <= pops_reg[src_c] + 1'b1;
                    end
                end
                total_reg <= total_reg + GW'(range_len);
                step_reg  <= step_reg + 1'b1;
            end
            pfgc_pkg::OP_GSTART:
            begin
                step_reg <= '0;
                cnt_reg  <= '0;
            end
            pfgc_pkg::OP_GLOAD:
            begin
                elem_reg      <= p_first;
                cur_last_reg  <= p_last;
                cur_empty_reg <= p_first > p_last;
                line_zero_reg <= !src_ok;
            end
            pfgc_pkg::OP_ELEM:
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                elem_reg <= elem_reg + 1'b1;
                if (elem_reg == cur_last_reg)
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
            pfgc_pkg::OP_SKIP:
            begin
                step_reg <= step_reg + 1'b1;
            end
            pfgc_pkg::OP_PAD:
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_acc_reg  <= 1'b0;
            out_val_reg  <= '0;
            out_idx_reg  <= '0;
            out_dest_reg <= '0;
            out_last_reg <= 1'b0;
            out_af_reg   <= 1'b0;
            out_ar_reg   <= 1'b0;
            out_ov_reg   <= 1'b0;
            case (cmd.op)
                pfgc_pkg::OP_PUSH:
                begin
                    out_kind_reg <= pfgc_pkg::KIND_PUSH_ACK;
                    out_acc_reg  <= push_ok;
                    out_af_reg   <= count_after >= CW'(FIFO_DEPTH - 4);
                    out_ar_reg   <= rc_after == exp_reg;
                end
                pfgc_pkg::OP_PROG:
                begin
                    out_kind_reg <= pfgc_pkg::KIND_PROG_ACK;
                    out_acc_reg  <= item_src_reg <= 3'(pfgc_pkg::CHANNELS);
                end
                pfgc_pkg::OP_STALL:
                begin
                    out_kind_reg <= pfgc_pkg::KIND_STALL;
                    out_dest_reg <= dest_reg;
                end
                default:
                begin
                    out_kind_reg <= pfgc_pkg::KIND_ELEMENT;
                    out_val_reg  <= (cmd.op == pfgc_pkg::OP_ELEM) ? elem_val : 16'd0;
                    out_idx_reg  <= cnt_reg[3:0];
                    out_dest_reg <= dest_reg;
                    out_last_reg <= cnt_reg == GW'(pfgc_pkg::OUT_ELEMENTS - 1);
                    out_ov_reg   <= total_reg > GW'(pfgc_pkg::OUT_ELEMENTS);
                end
            endcase
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.kind             = out_kind_reg;
    assign out_ch.accepted         = out_acc_reg;
    assign out_ch.element_value    = out_val_reg;
    assign out_ch.element_index    = out_idx_reg;
    assign out_ch.dest_channel     = out_dest_reg;
    assign out_ch.last             = out_last_reg;
    assign out_ch.fifo_almost_full = out_af_reg;
    assign out_ch.all_received     = out_ar_reg;
    assign out_ch.overflow         = out_ov_reg;

endmodule

// ===== hw/rtl/programmable_fifo_gather_crossbar.sv =====
// Top level of the programmable FIFO gather crossbar.
//
// Channels: in_ch carries requests (push a line, write a program step, issue
// the instruction at the program counter); out_ch returns results; cfg writes
// program_length (index 0), output_channel_count (1), expected_responses (2)
// and is always ready. Configure only while the block is idle.
// A request is taken only when the sequencer is idle. A push or program write
// returns one ack once the result register is free. An issue first scans the
// instruction's steps (up to 8 steps, each read from the program store and
// tallied per source FIFO, then a readiness check), then either returns one
// stall result or streams 16 element results; each step reads the program
// and line stores and then emits its selected elements, and padding fills
// the vector up to 16 elements. The steps are walked one at a time.
// Reset clears FIFO occupancy, the step-count valid bits, program counter,
// destination pointer and response count; line and step stores hold garbage until written.
// When out_ch stalls, the result register holds and the sequencer waits.
`timescale 1ns / 1ps
module programmable_fifo_gather_crossbar #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    pfgc_in_if.sink    in_ch,
    pfgc_out_if.source out_ch,
    pfgc_cfg_if.sink   cfg
);

    // command and status between sequencer and datapath
    pfgc_pkg::dp_cmd_t  cmd;
    pfgc_pkg::dp_stat_t stat;

    // sequencer: walk program steps, pace element emission
    pfgc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath: FIFOs, program store, result register
    pfgc_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule
